@@ rtl/gamepad_console_responder_top_defines.svh @@
// Assertion macros for the gamepad console responder
`ifndef GAMEPAD_CONSOLE_RESPONDER_TOP_DEFINES_SVH
`define GAMEPAD_CONSOLE_RESPONDER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define GCR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gcr assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define GCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gcr assertion failed");

`endif

@@ rtl/gcr_pkg.sv @@
// Shared types and constants for the gamepad console responder
package gcr_pkg;

    localparam int OP_W   = 3;
    localparam int BYTE_W = 8;
    localparam int OUT_TDATA_W = 16;

    localparam logic [OP_W-1:0] OP_ATT_FALL = 3'd0;
    localparam logic [OP_W-1:0] OP_CONSOLE  = 3'd1;
    localparam logic [OP_W-1:0] OP_ATT_RISE = 3'd2;
    localparam logic [OP_W-1:0] OP_HOST     = 3'd3;
    localparam logic [OP_W-1:0] OP_IDLE     = 3'd4;

    localparam logic [1:0] HOST_NONE = 2'd0;
    localparam logic [1:0] HOST_ACK  = 2'd1;
    localparam logic [1:0] HOST_ERR  = 2'd2;

    localparam logic [15:0] TICKS_RESET = 16'd30000;

    typedef struct packed {
        logic [7:0] reply_byte;
        logic       ack;
        logic       transaction_end;
        logic [1:0] host_reply;
    } result_t;

endpackage

@@ rtl/gcr_core.sv @@
// Controller state and per-transaction reply logic
module gcr_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic [2:0]        op,
    input  logic [7:0]        data,
    input  logic [15:0]       disconnect_ticks,
    output gcr_pkg::result_t  res
);
    import gcr_pkg::*;

    localparam logic [7:0] SYNC_BYTE   = 8'h5A;
    localparam logic [7:0] ID_DIGITAL  = 8'h41;
    localparam logic [7:0] ID_ANALOG   = 8'h73;
    localparam logic [7:0] ID_PRESSURE = 8'h79;
    localparam logic [7:0] ID_CONFIG   = 8'hF3;
    localparam logic [7:0] START_BYTE  = 8'h01;

    localparam logic [7:0] CMD_40 = 8'h40;
    localparam logic [7:0] CMD_41 = 8'h41;
    localparam logic [7:0] CMD_ENTER_EXIT = 8'h43;
    localparam logic [7:0] CMD_SET_MODE   = 8'h44;
    localparam logic [7:0] CMD_45 = 8'h45;
    localparam logic [7:0] CMD_46 = 8'h46;
    localparam logic [7:0] CMD_47 = 8'h47;
    localparam logic [7:0] CMD_4C = 8'h4C;
    localparam logic [7:0] CMD_MOTOR    = 8'h4D;
    localparam logic [7:0] CMD_PRESSURE = 8'h4F;

    localparam logic [1:0] KIND_DIGITAL  = 2'd0;
    localparam logic [1:0] KIND_ANALOG   = 2'd1;
    localparam logic [1:0] KIND_PRESSURE = 2'd2;

    // Reply tables, entry 0 in the low byte
    localparam logic [47:0] T40   = 48'h5A_00_00_02_00_00;
    localparam logic [47:0] T41A  = 48'h5A_00_00_03_FF_FF;
    localparam logic [47:0] T45   = 48'h00_01_02_00_02_03;
    localparam logic [47:0] T46A  = 48'h0F_00_02_01_00_00;
    localparam logic [47:0] T46B  = 48'h0F_01_01_01_00_00;
    localparam logic [47:0] T47   = 48'h00_01_00_02_00_00;
    localparam logic [47:0] T4CA  = 48'h00_00_04_00_00_00;
    localparam logic [47:0] T4CB  = 48'h00_00_07_00_00_00;
    localparam logic [47:0] T4F   = 48'h5A_00_00_00_00_00;

    typedef struct packed {
        logic [7:0]      held_lo;
        logic [7:0]      held_hi;
        logic [7:0]      queued_lo;
        logic [7:0]      queued_hi;
        logic [3:0][7:0] stick;
        logic            in_config;
        logic [1:0]      report_kind;
        logic            analog_on;
        logic [1:0][7:0] motor;
        logic [2:0]      frame_pos;
        logic            update_pending;
        logic [15:0]     idle_count;
        logic [4:0]      byte_pos;
        logic [7:0]      command_seen;
        logic [7:0]      first_param;
        logic            finished;
        logic            att_low;
    } state_t;

    localparam state_t STATE_RESET = '{
        held_lo: 8'hFF, held_hi: 8'hFF, queued_lo: 8'hFF, queued_hi: 8'hFF,
        stick: {4{8'h80}}, in_config: 1'b0, report_kind: KIND_DIGITAL,
        analog_on: 1'b0, motor: {2{8'hFF}}, frame_pos: 3'd0,
        update_pending: 1'b0, idle_count: 16'd0, byte_pos: 5'd0,
        command_seen: 8'd0, first_param: 8'd0, finished: 1'b0, att_low: 1'b0};

    function automatic logic [7:0] pick(input logic [47:0] t, input logic [2:0] i);
        pick = t[{i, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] press(input logic b);
        press = b ? 8'h00 : 8'hFF;
    endfunction

    function automatic logic known_cmd(input logic [7:0] c);
        case (c) inside
            CMD_40, CMD_41, CMD_ENTER_EXIT, CMD_SET_MODE, CMD_45, CMD_46, CMD_47,
            CMD_4C, CMD_MOTOR, CMD_PRESSURE: known_cmd = 1'b1;
            default: known_cmd = 1'b0;
        endcase
    endfunction

    function automatic logic [7:0] poll_byte(input state_t s, input logic [4:0] i);
        case (i)
            5'd0:  poll_byte = s.held_lo;
            5'd1:  poll_byte = s.held_hi;
            5'd2:  poll_byte = s.stick[0];
            5'd3:  poll_byte = s.stick[1];
            5'd4:  poll_byte = s.stick[2];
            5'd5:  poll_byte = s.stick[3];
            5'd6:  poll_byte = press(s.held_lo[5]);
            5'd7:  poll_byte = press(s.held_lo[7]);
            5'd8:  poll_byte = press(s.held_lo[4]);
            5'd9:  poll_byte = press(s.held_lo[6]);
            5'd10: poll_byte = press(s.held_hi[4]);
            5'd11: poll_byte = press(s.held_hi[5]);
            5'd12: poll_byte = press(s.held_hi[6]);
            5'd13: poll_byte = press(s.held_hi[7]);
            5'd14: poll_byte = press(s.held_hi[2]);
            5'd15: poll_byte = press(s.held_hi[3]);
            5'd16: poll_byte = press(s.held_hi[0]);
            5'd17: poll_byte = press(s.held_hi[1]);
            default: poll_byte = 8'hFF;
        endcase
    endfunction

    function automatic logic [7:0] cfg_byte(input state_t s, input logic [4:0] i);
        logic [2:0] k;
        logic       fp_one;
        k = i[2:0];
        fp_one = (s.first_param == 8'd1);
        if (i > 5'd5) begin
            cfg_byte = 8'hFF;
        end else begin
            case (s.command_seen)
                CMD_40: cfg_byte = pick(T40, k);
                CMD_41: cfg_byte = s.analog_on ? pick(T41A, k) : 8'h00;
                CMD_45: cfg_byte = (k == 3'd2) ? {7'd0, s.analog_on} : pick(T45, k);
                CMD_46: cfg_byte = fp_one ? pick(T46B, k) : pick(T46A, k);
                CMD_47: cfg_byte = pick(T47, k);
                CMD_4C: cfg_byte = fp_one ? pick(T4CB, k) : pick(T4CA, k);
                CMD_MOTOR: cfg_byte = (k < 3'd2) ? s.motor[k[0]] : 8'hFF;
                CMD_PRESSURE: cfg_byte = pick(T4F, k);
                default: cfg_byte = 8'h00;
            endcase
        end
    endfunction

    function automatic logic [7:0] next_reply(input state_t s);
        logic [4:0] idx;
        idx = s.byte_pos - 5'd3;
        if (!(s.att_low && !s.finished) || s.byte_pos == 5'd0) begin
            next_reply = 8'hFF;
        end else if (s.byte_pos == 5'd1) begin
            if (s.in_config) next_reply = ID_CONFIG;
            else if (s.report_kind == KIND_ANALOG) next_reply = ID_ANALOG;
            else if (s.report_kind == KIND_PRESSURE) next_reply = ID_PRESSURE;
            else next_reply = ID_DIGITAL;
        end else if (s.byte_pos == 5'd2) begin
            next_reply = SYNC_BYTE;
        end else begin
            next_reply = s.in_config ? cfg_byte(s, idx) : poll_byte(s, idx);
        end
    endfunction

    state_t      state_reg;
    state_t      state_next;
    logic        busy;
    logic        ack_c;
    logic        end_c;
    logic [1:0]  host_c;
    logic [4:0]  p;
    logic [4:0]  last_pos;
    logic [15:0] idle_inc;

    assign busy = state_reg.att_low && !state_reg.finished;
    assign p    = state_reg.byte_pos;
    assign idle_inc = state_reg.idle_count + 16'd1;

    always_comb
    begin
        state_next = state_reg;
        ack_c  = 1'b0;
        end_c  = 1'b0;
        host_c = HOST_NONE;
        case (state_reg.report_kind)
            KIND_ANALOG:   last_pos = 5'd8;
            KIND_PRESSURE: last_pos = 5'd20;
            default:       last_pos = 5'd4;
        endcase
        unique case (op)
            OP_ATT_FALL:
            begin
                state_next.att_low    = 1'b1;
                state_next.finished   = 1'b0;
                state_next.byte_pos   = 5'd0;
                state_next.idle_count = 16'd0;
            end
            OP_CONSOLE:
            begin
                if (busy)
                begin
                    ack_c = 1'b1;
                    if (p == 5'd0)
                    begin
                        end_c = (data != START_BYTE);
                    end
                    else if (p == 5'd1)
                    begin
                        state_next.command_seen = data;
                    end
                    else if (p == 5'd2)
                    begin
                        if (state_reg.in_config)
                        begin
                            if (state_reg.command_seen == CMD_PRESSURE)
                                state_next.report_kind = KIND_PRESSURE;
                            end_c = !known_cmd(state_reg.command_seen);
                        end
                    end
                    else
                    begin
                        if (p == 5'd3)
                            state_next.first_param = data;
                        if (state_reg.in_config)
                        begin
                            if (state_reg.command_seen == CMD_MOTOR && p < 5'd5)
                                state_next.motor[~p[0]] = data;
                            if ((state_reg.command_seen == CMD_46 ||
                                 state_reg.command_seen == CMD_4C) &&
                                p == 5'd3 && data > 8'd1)
                            begin
                                end_c = 1'b1;
                            end
                            else if (p >= 5'd8)
                            begin
                                ack_c = 1'b0;
                                end_c = 1'b1;
                                if (state_reg.command_seen == CMD_ENTER_EXIT &&
                                    state_reg.first_param == 8'd0)
                                    state_next.in_config = 1'b0;
                                if (state_reg.command_seen == CMD_SET_MODE)
                                begin
                                    if (state_reg.first_param == 8'd1)
                                    begin
                                        state_next.report_kind = KIND_ANALOG;
                                        state_next.analog_on   = 1'b1;
                                    end
                                    else
                                    begin
                                        state_next.report_kind = KIND_DIGITAL;
                                        state_next.analog_on   = 1'b0;
                                    end
                                end
                            end
                        end
                        else if (p >= last_pos)
                        begin
                            ack_c = 1'b0;
                            end_c = 1'b1;
                            if (state_reg.command_seen == CMD_ENTER_EXIT &&
                                state_next.first_param == 8'd1)
                                state_next.in_config = 1'b1;
                        end
                    end
                    if (end_c)
                        state_next.finished = 1'b1;
                    else
                        state_next.byte_pos = p + 5'd1;
                end
            end
            OP_ATT_RISE:
            begin
                if (busy)
                    end_c = 1'b1;
                state_next.att_low = 1'b0;
            end
            OP_HOST:
            begin
                case (state_reg.frame_pos)
                    3'd0:
                    begin
                        if (data == SYNC_BYTE) state_next.frame_pos = 3'd1;
                        else host_c = HOST_ERR;
                    end
                    3'd1:
                    begin
                        state_next.held_lo   = state_reg.held_lo & data;
                        state_next.queued_lo = data;
                        state_next.frame_pos = 3'd2;
                    end
                    3'd2:
                    begin
                        state_next.held_hi   = state_reg.held_hi & data;
                        state_next.queued_hi = data;
                        state_next.frame_pos = 3'd3;
                    end
                    3'd3:
                    begin
                        state_next.stick[0]  = data;
                        state_next.frame_pos = 3'd4;
                    end
                    3'd4:
                    begin
                        state_next.stick[1]  = data;
                        state_next.frame_pos = 3'd5;
                    end
                    3'd5:
                    begin
                        state_next.stick[2]  = data;
                        state_next.frame_pos = 3'd6;
                    end
                    3'd6:
                    begin
                        state_next.stick[3]       = data;
                        state_next.frame_pos      = 3'd0;
                        state_next.update_pending = 1'b1;
                    end
                    default: state_next.frame_pos = 3'd0;
                endcase
            end
            OP_IDLE:
            begin
                if (state_reg.att_low)
                begin
                    state_next.idle_count = 16'd0;
                end
                else
                begin
                    state_next.idle_count = idle_inc;
                    if (idle_inc >= disconnect_ticks)
                    begin
                        state_next.report_kind = KIND_DIGITAL;
                        state_next.analog_on   = 1'b0;
                        state_next.in_config   = 1'b0;
                        state_next.motor       = {2{8'hFF}};
                        state_next.idle_count  = 16'd0;
                    end
                end
            end
            default: ;
        endcase
        // End-of-transaction bookkeeping: releases land, pending update is acknowledged
        if (end_c)
        begin
            state_next.held_lo = state_reg.queued_lo;
            state_next.held_hi = state_reg.queued_hi;
            if (state_reg.update_pending)
            begin
                host_c = HOST_ACK;
                state_next.update_pending = 1'b0;
            end
        end
    end

    always_comb
    begin
        res.reply_byte      = next_reply(state_next);
        res.ack             = ack_c;
        res.transaction_end = !(state_next.att_low && !state_next.finished);
        res.host_reply      = host_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= STATE_RESET;
        else if (en)
            state_reg <= state_next;
    end

endmodule

@@ rtl/gamepad_console_responder_top.sv @@
// Top level: stream handshake registers, APB register and responder core
// An accepted transaction waits in the input register. When it advances, the core
// state and the output register take its result at the same edge, and m_tvalid rises.
// Throughput: one transaction per cycle, m_tready permitting. With m_tready low, the
// input register takes one more transaction behind the waiting result; then s_tready falls.
// Reset (rst_n low, asynchronous): controller state returns to its power-up
// values, both stream stages empty, disconnect_ticks back to 30000.
module gamepad_console_responder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data
    input  logic [2:0]  s_tuser,   // [2:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] reply_byte, [8] ack, [10:9] host_reply, rest zero
    output logic        m_tlast,   // transaction_end
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import gcr_pkg::*;

    logic        in_valid_reg;
    logic [2:0]  in_op_reg;
    logic [7:0]  in_data_reg;
    logic        out_valid_reg;
    result_t     out_res_reg;
    result_t     core_res;
    logic        advance;
    logic [15:0] ticks_reg;
    logic        reg_sel;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg   <= s_tuser;
            in_data_reg <= s_tdata;
        end
        if (advance)
            out_res_reg <= core_res;
    end

    gcr_core u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (advance),
        .op               (in_op_reg),
        .data             (in_data_reg),
        .disconnect_ticks (ticks_reg),
        .res              (core_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_res_reg.host_reply, out_res_reg.ack, out_res_reg.reply_byte};
    assign m_tlast  = out_res_reg.transaction_end;

    // Single register, selected at byte addresses 0 to 3 (paddr[2] low)
    assign reg_sel = !paddr[2];
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {16'd0, ticks_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ticks_reg <= TICKS_RESET;
        else if (psel && penable && pwrite && pready && reg_sel)
            ticks_reg <= pwdata[15:0];
    end

endmodule

@@ rtl/gcr_checker.sv @@
// Port-level checks for the gamepad console responder, bound to the top level
`include "gamepad_console_responder_top_defines.svh"

module gcr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);
    import gcr_pkg::*;

    // A result stalled by the sink stays offered
    `GCR_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid)

    // Outside a transaction the reply byte is all ones
    `GCR_ASSERT_IMPLY(a_idle_reply, clk, rst_n, m_tvalid && m_tlast, m_tdata[7:0] == 8'hFF)

    // A console byte acknowledge never comes with a framing error
    `GCR_ASSERT_IMPLY(a_ack_no_err, clk, rst_n, m_tvalid && m_tdata[8],
        m_tdata[10:9] != HOST_ERR)

    // Host reply code is never the unused value and padding stays zero
    `GCR_ASSERT_IMPLY(a_host_code, clk, rst_n, m_tvalid,
        !(m_tdata[10] && m_tdata[9]) && m_tdata[15:11] == 5'd0)

endmodule

bind gamepad_console_responder_top gcr_checker u_gcr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

@@ tb/sv/tb_gamepad_console_responder_top.sv @@
// Self-checking stream testbench for the gamepad console responder top level
`timescale 1ns / 100ps

module tb_gamepad_console_responder_top;
    import gcr_pkg::*;

    localparam logic [2:0]  TICKS_ADDR  = 3'd0;
    localparam logic [2:0]  OP_SPARE_LO = 3'd5;
    localparam logic [2:0]  OP_SPARE_HI = 3'd7;

    localparam logic [7:0]  START_BYTE  = 8'h01;
    localparam logic [7:0]  SYNC_BYTE   = 8'h5A;
    localparam logic [7:0]  CFG_ID      = 8'hF3;
    localparam logic [7:0]  ID_DIGITAL  = 8'h41;
    localparam logic [7:0]  ID_ANALOG   = 8'h73;
    localparam logic [7:0]  ID_PRESSURE = 8'h79;

    localparam logic [7:0]  CMD_PRESSURE_INIT = 8'h40;
    localparam logic [7:0]  CMD_BUTTON_MASK   = 8'h41;
    localparam logic [7:0]  CMD_POLL          = 8'h42;
    localparam logic [7:0]  CMD_CONFIG        = 8'h43;
    localparam logic [7:0]  CMD_SET_MODE      = 8'h44;
    localparam logic [7:0]  CMD_MODEL         = 8'h45;
    localparam logic [7:0]  CMD_ACT           = 8'h46;
    localparam logic [7:0]  CMD_COMB          = 8'h47;
    localparam logic [7:0]  CMD_QUERY_MODE    = 8'h4C;
    localparam logic [7:0]  CMD_MOTOR_MAP     = 8'h4D;
    localparam logic [7:0]  CMD_PRESSURE_CFG  = 8'h4F;

    localparam logic [1:0]  KIND_DIGITAL  = 2'd0;
    localparam logic [1:0]  KIND_ANALOG   = 2'd1;
    localparam logic [1:0]  KIND_PRESSURE = 2'd2;

    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 140;

    // Controller model plus the queue of replies still owed by the block
    class reply_tracker;
        logic [15:0] ticks;
        logic [7:0]  held_lo, held_hi, queued_lo, queued_hi;
        logic [7:0]  sticks [4];
        logic [7:0]  motors [2];
        logic        cfg_mode, analog_on, upd_pending, att_low, done;
        logic [1:0]  kind;
        logic [2:0]  frame_pos;
        logic [15:0] idle_cnt;
        logic [4:0]  pos;
        logic [7:0]  cmd, param;
        logic        ack_now;
        logic [1:0]  host_now;
        result_t     expected_replies [$];
        int          mismatches, checked, disconnects, cfg_entries, deep_polls;

        function new();
            ticks = TICKS_RESET;
            held_lo = 8'hFF; held_hi = 8'hFF; queued_lo = 8'hFF; queued_hi = 8'hFF;
            foreach (sticks[i]) sticks[i] = 8'h80;
            motors[0] = 8'hFF; motors[1] = 8'hFF;
            cfg_mode = 0; analog_on = 0; upd_pending = 0; att_low = 0; done = 0;
            kind = KIND_DIGITAL; frame_pos = 0; idle_cnt = 0; pos = 0; cmd = 0; param = 0;
            mismatches = 0; checked = 0; disconnects = 0; cfg_entries = 0; deep_polls = 0;
        endfunction

        function logic busy();
            return att_low && !done;
        endfunction

        function logic [7:0] mode_id();
            case (kind)
                KIND_ANALOG:   return ID_ANALOG;
                KIND_PRESSURE: return ID_PRESSURE;
                default:       return ID_DIGITAL;
            endcase
        endfunction

        // pressure reads full scale while the button is held (bit low)
        function logic [7:0] press(logic [7:0] b, logic [7:0] m);
            return ((b & m) != 0) ? 8'h00 : 8'hFF;
        endfunction

        function logic [7:0] poll_byte(int i);
            case (i)
                0:  return held_lo;
                1:  return held_hi;
                2, 3, 4, 5: return sticks[i-2];
                6:  return press(held_lo, 8'h20);
                7:  return press(held_lo, 8'h80);
                8:  return press(held_lo, 8'h10);
                9:  return press(held_lo, 8'h40);
                10: return press(held_hi, 8'h10);
                11: return press(held_hi, 8'h20);
                12: return press(held_hi, 8'h40);
                13: return press(held_hi, 8'h80);
                14: return press(held_hi, 8'h04);
                15: return press(held_hi, 8'h08);
                16: return press(held_hi, 8'h01);
                17: return press(held_hi, 8'h02);
                default: return 8'hFF;
            endcase
        endfunction

        // fixed answer tables, byte 0 in the low bits
        function logic [7:0] cfg_byte(int i);
            logic [47:0] tab;
            if (i > 5)
                return 8'hFF;
            case (cmd)
                CMD_PRESSURE_INIT: tab = 48'h5A_00_00_02_00_00;
                CMD_BUTTON_MASK:
                begin
                    if (!analog_on)
                        return 8'h00;
                    tab = 48'h5A_00_00_03_FF_FF;
                end
                CMD_MODEL:
                begin
                    if (i == 2)
                        return analog_on ? 8'h01 : 8'h00;
                    tab = 48'h00_01_02_00_02_03;
                end
                CMD_ACT:        tab = (param == 1) ? 48'h0F_01_01_01_00_00
                                                   : 48'h0F_00_02_01_00_00;
                CMD_COMB:       tab = 48'h00_01_00_02_00_00;
                CMD_QUERY_MODE: tab = (param == 1) ? 48'h00_00_07_00_00_00
                                                   : 48'h00_00_04_00_00_00;
                CMD_MOTOR_MAP:  return (i < 2) ? motors[i] : 8'hFF;
                CMD_PRESSURE_CFG: tab = 48'h5A_00_00_00_00_00;
                default: return 8'h00;
            endcase
            return tab[8*i +: 8];
        endfunction

        function logic [7:0] next_reply();
            if (!busy() || pos == 0)
                return 8'hFF;
            if (pos == 1)
                return cfg_mode ? CFG_ID : mode_id();
            if (pos == 2)
                return SYNC_BYTE;
            return cfg_mode ? cfg_byte(int'(pos) - 3) : poll_byte(int'(pos) - 3);
        endfunction

        function logic known_cmd(logic [7:0] c);
            case (c)
                CMD_PRESSURE_INIT, CMD_BUTTON_MASK, CMD_CONFIG, CMD_SET_MODE, CMD_MODEL,
                CMD_ACT, CMD_COMB, CMD_QUERY_MODE, CMD_MOTOR_MAP, CMD_PRESSURE_CFG:
                    return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        function logic [1:0] close_transaction();
            held_lo = queued_lo;
            held_hi = queued_hi;
            if (upd_pending)
            begin
                upd_pending = 0;
                return HOST_ACK;
            end
            return HOST_NONE;
        endfunction

        function void take_console(logic [7:0] d);
            int p;
            int final_pos;
            logic last_byte;
            p = int'(pos);
            last_byte = 0;
            ack_now = 1;
            if (p == 0)
                last_byte = (d != START_BYTE);
            else if (p == 1)
                cmd = d;
            else if (p == 2)
            begin
                if (cfg_mode)
                begin
                    if (cmd == CMD_PRESSURE_CFG)
                        kind = KIND_PRESSURE;
                    if (!known_cmd(cmd))
                        last_byte = 1;
                end
            end
            else
            begin
                if (p == 3)
                    param = d;
                if (cfg_mode)
                begin
                    if (cmd == CMD_MOTOR_MAP && p < 5)
                        motors[(p - 3) & 1] = d;
                    if ((cmd == CMD_ACT || cmd == CMD_QUERY_MODE) && p == 3 && d > 1)
                        last_byte = 1;
                    else if (p >= 8)
                    begin
                        ack_now = 0;
                        last_byte = 1;
                        if (cmd == CMD_CONFIG && param == 0)
                            cfg_mode = 0;
                        if (cmd == CMD_SET_MODE)
                        begin
                            analog_on = (param == 1);
                            kind = (param == 1) ? KIND_ANALOG : KIND_DIGITAL;
                        end
                    end
                end
                else
                begin
                    final_pos = (kind == KIND_ANALOG) ? 8 : (kind == KIND_PRESSURE) ? 20 : 4;
                    if (p >= final_pos)
                    begin
                        ack_now = 0;
                        last_byte = 1;
                        if (kind == KIND_PRESSURE)
                            deep_polls++;
                        if (cmd == CMD_CONFIG && param == 1)
                        begin
                            cfg_mode = 1;
                            cfg_entries++;
                        end
                    end
                end
            end
            if (last_byte)
            begin
                done = 1;
                host_now = close_transaction();
            end
            else
                pos = pos + 5'd1;
        endfunction

        function void take_host(logic [7:0] d);
            case (frame_pos)
                3'd0:
                begin
                    if (d == SYNC_BYTE)
                        frame_pos = 3'd1;
                    else
                        host_now = HOST_ERR;
                end
                3'd1:
                begin
                    held_lo &= d; queued_lo = d; frame_pos = 3'd2;
                end
                3'd2:
                begin
                    held_hi &= d; queued_hi = d; frame_pos = 3'd3;
                end
                3'd3:
                begin
                    sticks[0] = d; frame_pos = 3'd4;
                end
                3'd4:
                begin
                    sticks[1] = d; frame_pos = 3'd5;
                end
                3'd5:
                begin
                    sticks[2] = d; frame_pos = 3'd6;
                end
                3'd6:
                begin
                    sticks[3] = d; frame_pos = 3'd0; upd_pending = 1;
                end
                default: frame_pos = 3'd0;
            endcase
        endfunction

        // returns 0 when the block merely ignores the item
        function logic note_item(logic [2:0] op, logic [7:0] d);
            result_t r;
            logic counted;
            counted = 1;
            ack_now = 0;
            host_now = HOST_NONE;
            case (op)
                OP_ATT_FALL:
                begin
                    att_low = 1; done = 0; pos = 0; idle_cnt = 0;
                end
                OP_CONSOLE:
                begin
                    if (busy())
                        take_console(d);
                    else
                        counted = 0;
                end
                OP_ATT_RISE:
                begin
                    if (busy())
                        host_now = close_transaction();
                    att_low = 0;
                end
                OP_HOST: take_host(d);
                OP_IDLE:
                begin
                    if (att_low)
                        idle_cnt = 0;
                    else
                    begin
                        idle_cnt = idle_cnt + 16'd1;
                        if (idle_cnt >= ticks)
                        begin
                            kind = KIND_DIGITAL; analog_on = 0; cfg_mode = 0;
                            motors[0] = 8'hFF; motors[1] = 8'hFF;
                            idle_cnt = 0;
                            disconnects++;
                        end
                    end
                end
                default: counted = 0;
            endcase
            r.reply_byte      = next_reply();
            r.ack             = ack_now;
            r.transaction_end = !busy();
            r.host_reply      = host_now;
            expected_replies.push_back(r);
            return counted;
        endfunction

        function void report_mismatch(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s", $time, what);
        endfunction

        function void check_reply(logic [15:0] tdata, logic tlast);
            result_t want;
            checked++;
            if (expected_replies.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing expected: tdata %04h tlast %0b",
                                          tdata, tlast));
                return;
            end
            want = expected_replies.pop_front();
            if (tdata[7:0] !== want.reply_byte || tdata[8] !== want.ack ||
                tlast !== want.transaction_end || tdata[10:9] !== want.host_reply)
                report_mismatch($sformatf(
                    {"result %0d: expected reply %02h ack %0b end %0b host %0d, ",
                     "got reply %02h ack %0b end %0b host %0d"},
                    checked, want.reply_byte, want.ack, want.transaction_end, want.host_reply,
                    tdata[7:0], tdata[8], tlast, tdata[10:9]));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;   // [7:0] data
    logic [2:0]  s_tuser = 3'd0;   // [2:0] op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // [7:0] reply_byte, [8] ack, [10:9] host_reply
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    reply_tracker tracker = new();
    int           live_items = 0;
    logic         calm = 1'b0;
    logic         rx_calm = 1'b0;

    gamepad_console_responder_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [7:0] pick_command();
        if (!tracker.cfg_mode)
        begin
            case ($urandom_range(9))
                0, 1, 2: return CMD_CONFIG;
                3:       return rand_byte();
                default: return CMD_POLL;
            endcase
        end
        case ($urandom_range(11))
            0:  return CMD_PRESSURE_INIT;
            1:  return CMD_BUTTON_MASK;
            2:  return CMD_CONFIG;
            3:  return CMD_SET_MODE;
            4:  return CMD_MODEL;
            5:  return CMD_ACT;
            6:  return CMD_COMB;
            7:  return CMD_QUERY_MODE;
            8:  return CMD_MOTOR_MAP;
            9:  return CMD_PRESSURE_CFG;
            10: return CMD_POLL;
            default: return rand_byte();
        endcase
    endfunction

    function automatic logic [7:0] console_data(int k);
        case (k)
            0: return ($urandom_range(19) == 0) ? rand_byte() : START_BYTE;
            1: return pick_command();
            3:
            begin
                case ($urandom_range(4))
                    0:       return 8'd0;
                    1, 2:    return 8'd1;
                    3:       return 8'd2;
                    default: return rand_byte();
                endcase
            end
            default: return rand_byte();
        endcase
    endfunction

    task automatic send_item(input logic [2:0] op, input logic [7:0] d);
        int gap;
        gap = calm ? 0 : $urandom_range(11);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= d;
        do @(posedge clk); while (!s_tready);
        if (tracker.note_item(op, d))
            live_items++;
    endtask

    // s_tvalid is already low whenever nothing is outstanding
    task automatic wait_drained();
        if (tracker.expected_replies.size() != 0)
        begin
            s_tvalid <= 1'b0;
            while (tracker.expected_replies.size() != 0)
                @(posedge clk);
        end
    endtask

    task automatic write_ticks(input logic [15:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TICKS_ADDR;
        pwdata  <= {16'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        tracker.ticks = v;
        // straight into a read of the same register
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[15:0] !== v)
            tracker.report_mismatch($sformatf("disconnect_ticks read %04h, wrote %04h",
                                              prdata[15:0], v));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // host update frame; realigns a half-sent frame first, sometimes broken
    task automatic run_frame();
        int n;
        while (tracker.frame_pos != 3'd0)
            send_item(OP_HOST, rand_byte());
        n = ($urandom_range(9) == 0) ? $urandom_range(1, 6) : 7;
        send_item(OP_HOST, ($urandom_range(9) == 0) ? rand_byte() : SYNC_BYTE);
        for (int k = 1; k < n; k++)
            send_item(OP_HOST, rand_byte());
    endtask

    task automatic run_exchange();
        int quit_at;
        int k;
        quit_at = ($urandom_range(7) == 0) ? $urandom_range(0, 20) : 99;
        send_item(OP_ATT_FALL, rand_byte());
        k = 0;
        while (tracker.busy() && k < quit_at)
        begin
            send_item(OP_CONSOLE, console_data(k));
            if ($urandom_range(19) == 0)
                send_item(OP_HOST, rand_byte());
            if ($urandom_range(29) == 0)
                send_item(OP_IDLE, rand_byte());
            k++;
        end
        if ($urandom_range(9) == 0)
            send_item(OP_CONSOLE, rand_byte());
        // now and then attention stays low and the next fall restarts
        if ($urandom_range(15) != 0)
            send_item(OP_ATT_RISE, rand_byte());
    endtask

    task automatic run_directed();
        send_item(OP_IDLE, 8'h00);
        send_item(OP_CONSOLE, START_BYTE);       // attention high, ignored
        send_item(OP_SPARE_LO, 8'hFF);
        send_item(OP_SPARE_LO + 3'd1, 8'h00);
        send_item(OP_SPARE_HI, 8'hA5);
        send_item(OP_HOST, 8'h00);               // framing error
        send_item(OP_HOST, SYNC_BYTE);
        send_item(OP_HOST, 8'h00);
        send_item(OP_HOST, 8'h00);
        send_item(OP_HOST, 8'hFF);
        send_item(OP_HOST, 8'h00);
        send_item(OP_HOST, 8'h80);
        send_item(OP_HOST, 8'h7F);
        // digital poll that asks for config mode
        send_item(OP_ATT_FALL, 8'h00);
        send_item(OP_CONSOLE, START_BYTE);
        send_item(OP_CONSOLE, CMD_CONFIG);
        send_item(OP_CONSOLE, 8'h00);
        send_item(OP_CONSOLE, 8'h01);
        send_item(OP_CONSOLE, 8'h00);
        send_item(OP_CONSOLE, 8'hFF);            // after the end
        send_item(OP_ATT_RISE, 8'h00);
        // unknown command in config mode ends after the sync byte
        send_item(OP_ATT_FALL, 8'h00);
        send_item(OP_CONSOLE, START_BYTE);
        send_item(OP_CONSOLE, 8'h99);
        send_item(OP_CONSOLE, 8'h00);
        // restart mid transaction, idle with attention low, then abandon
        send_item(OP_ATT_FALL, 8'h00);
        send_item(OP_CONSOLE, START_BYTE);
        send_item(OP_ATT_FALL, 8'h00);
        send_item(OP_IDLE, 8'h00);
        send_item(OP_ATT_RISE, 8'h00);
    endtask

    function automatic logic [15:0] phase_ticks(int ph);
        case (ph)
            0: return 16'd1;
            1: return 16'd0;      // every idle tick with attention high disconnects
            2: return 16'd7;
            3: return 16'hFFFF;
            4: return 16'($urandom_range(2, 40));
            default: return TICKS_RESET;
        endcase
    endfunction

    // result side
    initial
    begin
        int stall;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(15) == 0)
                rx_calm = ($urandom_range(2) == 0);
            stall = rx_calm ? 0 : $urandom_range(11);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            tracker.check_reply(m_tdata, m_tlast);
        end
    end

    initial
    begin
        int target;
        int pick;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        wait_drained();
        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_ticks(phase_ticks(ph));
            target = live_items + PHASE_ITEMS;
            while (live_items < target)
            begin
                calm = ($urandom_range(4) == 0);
                pick = $urandom_range(19);
                if (pick < 9)
                    run_exchange();
                else if (pick < 13)
                    run_frame();
                else if (pick < 16)
                    repeat ($urandom_range(1, 24)) send_item(OP_IDLE, rand_byte());
                else if (pick < 19)
                    repeat ($urandom_range(1, 3)) send_item(3'($urandom_range(7)), rand_byte());
                else
                    wait_drained();
            end
            wait_drained();
        end
        repeat (8) @(posedge clk);
        if (tracker.expected_replies.size() != 0)
            tracker.report_mismatch($sformatf("%0d results never arrived",
                                              tracker.expected_replies.size()));
        $display("Drove %0d effective items over %0d threshold settings; %0d results checked.",
                 live_items, PHASES + 1, tracker.checked);
        $display("Saw %0d disconnect resets, %0d config entries, %0d full pressure polls.",
                 tracker.disconnects, tracker.cfg_entries, tracker.deep_polls);
        if (tracker.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Run timed out with %0d results outstanding.",
                 tracker.expected_replies.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
